// ===== hdl/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg: shared definitions for the binary to decimal ASCII converter
// Widths, constants, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int VALUE_BITS = 32;
  localparam int DIGITS     = 10;                     // decimal digits of a 32-bit value
  localparam int BCD_BITS   = 4 * DIGITS;
  localparam int DIG_IDX    = $clog2(DIGITS);
  localparam int STEP_BITS  = $clog2(VALUE_BITS + 1);
  localparam int WIDTH_BITS = 5;
  localparam int CHAR_BITS  = 6;

  localparam logic [WIDTH_BITS-1:0] MAX_WIDTH  = 5'd16;
  localparam logic [CHAR_BITS-1:0]  ASCII_ZERO = 6'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;    // capture input item, clear BCD
    logic shift;   // one double dabble step
    logic size;    // set digit count and first position
    logic emit;    // load one character into the output register
  } cmd_t;

  typedef struct packed {
    logic steps_done;
    logic last_pos;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/b2da_if.sv =====
// ----------------------------------------------------------------------------
// b2da_if: valid/ready channels of the converter
// Input channel carries the value and minimum width, result channel one char.
// ----------------------------------------------------------------------------
interface b2da_in_if;
  logic                                valid;
  logic                                ready;
  logic [b2da_pkg::VALUE_BITS-1:0]     value;
  logic [b2da_pkg::WIDTH_BITS-1:0]     min_width;

  modport source (output valid, output value, output min_width, input ready);
  modport sink   (input valid, input value, input min_width, output ready);
endinterface

interface b2da_out_if;
  logic                                valid;
  logic                                ready;
  logic [b2da_pkg::CHAR_BITS-1:0]      character;
  logic                                last;
  logic [b2da_pkg::WIDTH_BITS-1:0]     char_count;

  modport source (output valid, output character, output last, output char_count,
                  input ready);
  modport sink   (input valid, input character, input last, input char_count,
                  output ready);
endinterface

// ===== hdl/binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: 32-bit unsigned to zero padded decimal ASCII
// Converts each value by double dabble and streams its characters out.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                              transfer
//  in_ch     in   value[31:0], min_width[4:0]          valid & ready
//  out_ch    out  character[5:0], last, char_count[4:0] valid & ready, one per char
//
// Sequence: a value goes through a load, 32 dabble steps, a step-count check,
// a sizing step and one emit step per character (1 to 16); back pressure
// holds the emit steps. The double dabble loop is serial.
// Reset (rst_n low, synchronous) empties the output register and returns the
// sequencer to idle. A stalled output register holds the character stream;
// the next value is taken while the final character still waits.
//
module binary_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  b2da_in_if.sink     in_ch,
  b2da_out_if.source  out_ch
);

  b2da_pkg::cmd_t cmd;   // sequencer commands to the datapath
  b2da_pkg::sts_t sts;   // datapath status back to the sequencer

  // Sequencer: idle -> conversion steps -> sizing -> character output.
  b2da_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: binary/BCD shift registers, sizing logic, output register.
  // Padding falls out of the digit select: positions above the highest
  // nonzero digit read as zero.
  b2da_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_value       (in_ch.value),
    .in_min_width   (in_ch.min_width),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_character  (out_ch.character),
    .out_last       (out_ch.last),
    .out_char_count (out_ch.char_count)
  );

endmodule

// ===== hdl/b2da_ctrl.sv =====
// ----------------------------------------------------------------------------
// b2da_ctrl: converter sequencer
// Steps the datapath through load, dabble steps, sizing and character output.
// ----------------------------------------------------------------------------
module b2da_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  b2da_pkg::sts_t sts,
  output b2da_pkg::cmd_t cmd
);

  b2da_pkg::state_t state_r;
  b2da_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= b2da_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      b2da_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = b2da_pkg::ST_CONV;
        end
      end
      b2da_pkg::ST_CONV: begin
        if (sts.steps_done) begin
          state_nxt = b2da_pkg::ST_SIZE;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      b2da_pkg::ST_SIZE: begin
        cmd.size  = 1'b1;
        state_nxt = b2da_pkg::ST_EMIT;
      end
      b2da_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_pos) begin
            state_nxt = b2da_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = b2da_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/b2da_dp.sv =====
// ----------------------------------------------------------------------------
// b2da_dp: converter datapath
// Double dabble shift registers, digit sizing and the output register.
// ----------------------------------------------------------------------------
module b2da_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  b2da_pkg::cmd_t                      cmd,
  output b2da_pkg::sts_t                      sts,
  input  logic [b2da_pkg::VALUE_BITS-1:0]     in_value,
  input  logic [b2da_pkg::WIDTH_BITS-1:0]     in_min_width,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [b2da_pkg::CHAR_BITS-1:0]      out_character,
  output logic                                out_last,
  output logic [b2da_pkg::WIDTH_BITS-1:0]     out_char_count
);

  logic [b2da_pkg::VALUE_BITS-1:0] bin_r;
  logic [b2da_pkg::BCD_BITS-1:0]   bcd_r;
  logic [b2da_pkg::BCD_BITS-1:0]   bcd_adj;
  logic [b2da_pkg::STEP_BITS-1:0]  step_r;
  logic [b2da_pkg::WIDTH_BITS-1:0] minw_r;
  logic [b2da_pkg::WIDTH_BITS-1:0] total_r;
  logic [b2da_pkg::WIDTH_BITS-1:0] pos_r;
  logic [b2da_pkg::WIDTH_BITS-1:0] ndig;
  logic [b2da_pkg::WIDTH_BITS-1:0] total;
  logic [3:0]                      digit [b2da_pkg::DIGITS];
  logic [3:0]                      sel_digit;
  logic                            out_valid_r;
  logic [b2da_pkg::CHAR_BITS-1:0]  out_char_r;
  logic                            out_last_r;
  logic [b2da_pkg::WIDTH_BITS-1:0] out_count_r;

  always_comb begin
    for (int d = 0; d < b2da_pkg::DIGITS; d++) begin
      digit[d] = bcd_r[4*d +: 4];
      bcd_adj[4*d +: 4] = (digit[d] >= 4'd5) ? digit[d] + 4'd3 : digit[d];
    end
  end

  // highest nonzero digit, at least one digit
  always_comb begin
    ndig = b2da_pkg::WIDTH_BITS'(1);
    for (int d = 0; d < b2da_pkg::DIGITS; d++) begin
      if (digit[d] != 4'd0) begin
        ndig = b2da_pkg::WIDTH_BITS'(d + 1);
      end
    end
    total = (minw_r > ndig) ? minw_r : ndig;
  end

  // positions above the top digit are padding
  assign sel_digit = (pos_r < b2da_pkg::WIDTH_BITS'(b2da_pkg::DIGITS))
                   ? digit[pos_r[b2da_pkg::DIG_IDX-1:0]] : 4'd0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r  <= in_value;
      bcd_r  <= '0;
      step_r <= '0;
      minw_r <= (in_min_width > b2da_pkg::MAX_WIDTH) ? b2da_pkg::MAX_WIDTH : in_min_width;
    end else if (cmd.shift) begin
      bcd_r  <= {bcd_adj[b2da_pkg::BCD_BITS-2:0], bin_r[b2da_pkg::VALUE_BITS-1]};
      bin_r  <= {bin_r[b2da_pkg::VALUE_BITS-2:0], 1'b0};
      step_r <= step_r + 1'b1;
    end
    if (cmd.size) begin
      total_r <= total;
      pos_r   <= total - 1'b1;
    end else if (cmd.emit) begin
      pos_r   <= pos_r - 1'b1;
    end
    if (cmd.emit) begin
      out_char_r  <= b2da_pkg::ASCII_ZERO + {2'b00, sel_digit};
      out_last_r  <= (pos_r == '0);
      out_count_r <= total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.steps_done = (step_r == b2da_pkg::STEP_BITS'(b2da_pkg::VALUE_BITS));
  assign sts.last_pos   = (pos_r == '0);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_character  = out_char_r;
  assign out_last       = out_last_r;
  assign out_char_count = out_count_r;

endmodule

// ===== hdl/b2da_chk.sv =====
// ----------------------------------------------------------------------------
// b2da_chk: port level checks for the converter
// Output hold, busy during a character stream, digit range, constant count.
// ----------------------------------------------------------------------------
module b2da_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [b2da_pkg::CHAR_BITS-1:0]    out_character,
  input logic                              out_last,
  input logic [b2da_pkg::WIDTH_BITS-1:0]   out_char_count
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character)
      && $stable(out_last) && $stable(out_char_count))
    else $error("result changed while stalled");

  // no new value taken mid-stream
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready during character stream");

  a_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_character >= 6'd48 && out_character <= 6'd57)
    else $error("character outside '0'..'9'");

  // next character follows at once with the same count
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && $stable(out_char_count))
    else $error("character count changed within a value");

endmodule

bind binary_to_decimal_ascii b2da_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_character  (out_ch.character),
  .out_last       (out_ch.last),
  .out_char_count (out_ch.char_count)
);

// ===== tb/b2da_checker.sv =====
// ----------------------------------------------------------------------------
// b2da_checker: result checker for the binary to decimal ASCII converter
// Watches both channels, predicts the character stream of every accepted
// value and compares each result transfer against it field by field.
// ----------------------------------------------------------------------------
module b2da_checker (
  input  logic clk,
  input  logic rst_n,
  b2da_in_if   in_ch,
  b2da_out_if  out_ch,
  output int   fail_count,
  output int   chars_pending
);

  typedef struct packed {
    logic [b2da_pkg::CHAR_BITS-1:0]  character;
    logic                            last;
    logic [b2da_pkg::WIDTH_BITS-1:0] char_count;
  } ascii_char_t;

  ascii_char_t char_queue[$];
  ascii_char_t head;

  // Decimal text of one value: padding zeros first, then digits MSD first.
  task automatic queue_decimal_text(input logic [b2da_pkg::VALUE_BITS-1:0] value,
                                    input logic [b2da_pkg::WIDTH_BITS-1:0] min_width);
    logic [3:0]                      digit [b2da_pkg::DIGITS];
    logic [b2da_pkg::VALUE_BITS-1:0] rest;
    int                              ndig;
    int                              width;
    int                              total;
    int                              pad;
    ascii_char_t                     c;
    rest = value;
    ndig = 1;
    for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
      digit[i] = 4'(rest % 10);
      rest     = rest / 10;
      if (digit[i] != 4'd0) ndig = i + 1;
    end
    width = (min_width > b2da_pkg::MAX_WIDTH) ? int'(b2da_pkg::MAX_WIDTH) : int'(min_width);
    total = (width > ndig) ? width : ndig;
    pad   = total - ndig;
    for (int k = 0; k < total; k++) begin
      if (k < pad) c.character = b2da_pkg::ASCII_ZERO;
      else c.character = b2da_pkg::ASCII_ZERO
                       + b2da_pkg::CHAR_BITS'(digit[ndig - 1 - (k - pad)]);
      c.last       = (k == total - 1);
      c.char_count = b2da_pkg::WIDTH_BITS'(total);
      char_queue.push_back(c);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      char_queue.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (char_queue.size() == 0) begin
          $error("character: none expected, actual %0d", out_ch.character);
          fail_count++;
        end else begin
          head = char_queue.pop_front();
          if (out_ch.character !== head.character) begin
            $error("character: expected %0d, actual %0d", head.character, out_ch.character);
            fail_count++;
          end
          if (out_ch.last !== head.last) begin
            $error("last: expected %0d, actual %0d", head.last, out_ch.last);
            fail_count++;
          end
          if (out_ch.char_count !== head.char_count) begin
            $error("char_count: expected %0d, actual %0d", head.char_count,
                   out_ch.char_count);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) queue_decimal_text(in_ch.value, in_ch.min_width);
    end
    chars_pending = char_queue.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top for the binary to decimal ASCII converter
// Drives directed and random values with random idle gaps on the input and
// random back pressure on the result channel; the checker beside the block
// predicts every character and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  // Sized for the worst case per value, 16 chars each behind the longest stall,
  // plus the longest input gap plus the work of one value, over 180 values.
  localparam int CYCLE_LIMIT   = 800000;
  localparam int SETTLE_CYCLES = 64;    // a bit over one full conversion
  localparam int RANDOM_ITEMS  = 157;

  logic clk;
  logic rst_n;
  bit   no_idle;        // set during a stretch run at full rate on both sides
  int   fail_count;
  int   chars_pending;
  int   cycle_count;

  b2da_in_if  in_ch ();
  b2da_out_if out_ch ();

  binary_to_decimal_ascii DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  b2da_checker text_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .chars_pending (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Value mix: full range, short numbers, digit-count boundaries, near all-ones.
  function automatic logic [31:0] pick_value();
    logic [31:0] p;
    int          k;
    p = 32'd1;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 9);
      2: return $urandom_range(0, 99999);
      3: begin
        k = $urandom_range(1, 9);
        repeat (k) p = p * 32'd10;
        return p + $urandom_range(0, 2) - 32'd1;    // 10^k - 1, 10^k, 10^k + 1
      end
      default: return 32'hFFFF_FFFF - $urandom_range(0, 5);
    endcase
  endfunction

  // Widths mostly in range, some above the maximum to hit saturation.
  function automatic logic [4:0] pick_width();
    if ($urandom_range(0, 99) < 80) return 5'($urandom_range(0, 16));
    return 5'($urandom_range(17, 31));
  endfunction

  // One input transfer. Valid stays high across back-to-back values; it is
  // only lowered at the start of a gap, never in the step it is raised.
  task automatic send_value(input logic [31:0] value, input logic [4:0] min_width);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= value;
    in_ch.min_width <= min_width;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Watchdog: a run that never drains ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Result side back pressure: ready runs of random length, random stalls.
  initial begin
    int run;
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      run = no_idle ? 50 : $urandom_range(1, 12);
      repeat (run) @(negedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Stimulus
  initial begin
    in_ch.valid     = 1'b0;
    in_ch.value     = '0;
    in_ch.min_width = '0;
    no_idle         = 1'b0;
    rst_n           = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // zero value, unpadded and padded, width saturation above 16
    send_value(32'd0, 5'd0);
    send_value(32'd0, 5'd1);
    send_value(32'd0, 5'd5);
    send_value(32'd0, 5'd16);
    send_value(32'd0, 5'd17);
    send_value(32'd0, 5'd31);
    // single digits and digit-count boundaries
    send_value(32'd1, 5'd0);
    send_value(32'd9, 5'd2);
    send_value(32'd10, 5'd1);
    send_value(32'd99, 5'd2);
    send_value(32'd100, 5'd3);
    send_value(32'd999_999_999, 5'd9);
    send_value(32'd999_999_999, 5'd10);
    send_value(32'd1_000_000_000, 5'd0);
    // all ones: ten digits, width below, equal, one over, max and saturated
    send_value(32'hFFFF_FFFF, 5'd0);
    send_value(32'hFFFF_FFFF, 5'd10);
    send_value(32'hFFFF_FFFF, 5'd11);
    send_value(32'hFFFF_FFFF, 5'd16);
    send_value(32'hFFFF_FFFF, 5'd31);
    send_value(32'h8000_0000, 5'd12);
    send_value(32'd123_456_789, 5'd20);
    send_value(32'h5555_5555, 5'd15);
    send_value(32'hAAAA_AAAA, 5'd14);

    // random values; one stretch runs with no idling on either side
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = (i >= 70 && i < 100);
      send_value(pick_value(), pick_width());
    end
    no_idle = 1'b0;

    // drain: last transfer done, drop valid, wait for the stream to empty
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (chars_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/b2da_pkg.sv
hdl/b2da_if.sv
hdl/b2da_ctrl.sv
hdl/b2da_dp.sv
hdl/binary_to_decimal_ascii.sv
hdl/b2da_chk.sv
tb/b2da_checker.sv
tb/tb.sv
